// ===== sv/bbp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the bimodal branch predictor.
// No dependencies; every file but bbp_ram imports this package.
package bbp_pkg;

  localparam int MAX_INDEX_BITS = 12;
  localparam int TABLE_DEPTH    = 1 << MAX_INDEX_BITS;
  localparam int CTR_W          = 2;
  localparam int CFG_W          = 4;
  localparam int COUNT_W        = 32;
  localparam int PC_W           = 32;

  typedef logic [MAX_INDEX_BITS-1:0] idx_t;
  typedef logic [CTR_W-1:0]          ctr_t;
  typedef logic [CFG_W-1:0]          cfg_bits_t;
  typedef logic [COUNT_W-1:0]        count_t;

  localparam ctr_t CTR_MIN       = ctr_t'(0);
  localparam ctr_t CTR_WEAK_TAKEN = ctr_t'(2);
  localparam ctr_t CTR_MAX       = ctr_t'(3);

  // One classified branch waiting for the counter update
  typedef struct packed {
    idx_t idx;
    logic taken;
  } qent_t;

  // Table clearing sequencer status
  typedef struct packed {
    logic busy;
    idx_t addr;
  } clr_t;

  // Mask of the live index bits; out-of-range widths clamp to 1..MAX_INDEX_BITS
  function automatic idx_t idx_mask(cfg_bits_t bits);
    cfg_bits_t eff;
    idx_t      m;
    eff = bits;
    if (eff == cfg_bits_t'(0)) eff = cfg_bits_t'(1);
    if (eff > cfg_bits_t'(MAX_INDEX_BITS)) eff = cfg_bits_t'(MAX_INDEX_BITS);
    for (int i = 0; i < MAX_INDEX_BITS; i++) begin
      m[i] = (i < int'(eff));
    end
    return m;
  endfunction

  // Step a 2-bit saturating counter toward the outcome
  function automatic ctr_t ctr_step(ctr_t c, logic taken);
    ctr_t r;
    r = c;
    if (taken) begin
      if (c != CTR_MAX) r = c + ctr_t'(1);
    end else begin
      if (c != CTR_MIN) r = c - ctr_t'(1);
    end
    return r;
  endfunction

endpackage

// ===== sv/bbp_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: branch input, prediction result, config write.
// Depends on bbp_pkg for field widths.
interface bbp_branch_if;
  import bbp_pkg::*;
  logic            valid;
  logic            ready;
  logic [PC_W-1:0] pc;
  logic            taken;
  modport source (output valid, pc, taken, input ready);
  modport sink   (input valid, pc, taken, output ready);
endinterface

interface bbp_result_if;
  import bbp_pkg::*;
  logic   valid;
  logic   ready;
  logic   prediction;
  logic   mispredicted;
  count_t mispredict_count;
  modport source (output valid, prediction, mispredicted, mispredict_count, input ready);
  modport sink   (input valid, prediction, mispredicted, mispredict_count, output ready);
endinterface

interface bbp_cfg_if;
  import bbp_pkg::*;
  logic      valid;
  logic      ready;
  cfg_bits_t index_bits;
  modport source (output valid, index_bits, input ready);
  modport sink   (input valid, index_bits, output ready);
endinterface

// ===== sv/bbp_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== sv/bbp_front.sv =====
`timescale 1ns / 1ps
// Front end: holds the index width register, accepts branches, forms the table
// index and runs the post-reset table clearing pass. Depends on bbp_pkg, bbp_ifs.
module bbp_front (
  input  logic           clk,
  input  logic           rst,
  bbp_branch_if.sink     branch,
  bbp_cfg_if.sink        cfg,
  input  logic           q_ready,
  output logic           q_push,
  output bbp_pkg::qent_t q_data,
  output bbp_pkg::clr_t  clr
);
  import bbp_pkg::*;

  cfg_bits_t index_bits;
  logic      clr_busy;
  idx_t      clr_addr;

  // Config register, always writable
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits <= cfg_bits_t'(MAX_INDEX_BITS);
    end else if (cfg.valid) begin
      index_bits <= cfg.index_bits;
    end
  end

  // Sweep every table entry once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + idx_t'(1);
      if (clr_addr == idx_t'(TABLE_DEPTH - 1)) clr_busy <= 1'b0;
    end
  end
  assign clr.busy = clr_busy;
  assign clr.addr = clr_addr;

  // Accept a beat and classify it into a table index
  assign branch.ready = q_ready && !clr_busy;
  assign q_push       = branch.valid && branch.ready;
  assign q_data.idx   = branch.pc[MAX_INDEX_BITS+1:2] & idx_mask(index_bits);
  assign q_data.taken = branch.taken;

endmodule

// ===== sv/bbp_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue of classified branches between front and back end.
// Depends on bbp_pkg.
module bbp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bbp_pkg::qent_t push_data,
  output logic           push_ready,
  input  logic           pop,
  output logic           pop_valid,
  output bbp_pkg::qent_t pop_data
);
  import bbp_pkg::*;

  qent_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rd_ptr];

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== sv/bbp_back.sv =====
`timescale 1ns / 1ps
// Back end: reads a counter, forms prediction and miss, writes the stepped
// counter back and holds the result beat. Depends on bbp_pkg, bbp_ifs.
module bbp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  bbp_pkg::qent_t   q_data,
  output logic             q_pop,
  output logic             rd_en,
  output bbp_pkg::idx_t    rd_addr,
  input  bbp_pkg::ctr_t    rd_data,
  output logic             wr_en,
  output bbp_pkg::idx_t    wr_addr,
  output bbp_pkg::ctr_t    wr_data,
  bbp_result_if.source     result
);
  import bbp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } state_t;

  state_t state, state_next;
  qent_t  cur;
  logic   pred;
  logic   miss;
  logic   out_free;
  logic   out_valid;
  logic   out_pred;
  logic   out_miss;
  count_t miss_total;

  assign pred     = (rd_data >= CTR_WEAK_TAKEN);
  assign miss     = pred != cur.taken;
  assign out_free = !out_valid || result.ready;

  // Issue a read from IDLE, retire the update once the result slot frees
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    wr_en      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (out_free) begin
          wr_en      = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign rd_en   = q_pop;
  assign rd_addr = q_data.idx;
  assign wr_addr = cur.idx;
  assign wr_data = ctr_step(rd_data, cur.taken);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Latch the popped beat
  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  // Result register and running miss total
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      miss_total <= '0;
    end else begin
      if (wr_en) begin
        out_valid  <= 1'b1;
        miss_total <= miss_total + count_t'(miss);
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      out_pred <= pred;
      out_miss <= miss;
    end
  end

  assign result.valid            = out_valid;
  assign result.prediction       = out_pred;
  assign result.mispredicted     = out_miss;
  assign result.mispredict_count = miss_total;

endmodule

// ===== sv/bimodal_branch_predictor.sv =====
`timescale 1ns / 1ps
// Top level of the bimodal branch predictor: front end, queue, back end, table.
// Depends on bbp_pkg, bbp_ifs, bbp_ram, bbp_front, bbp_queue, bbp_back.

// Each accepted branch (pc, taken) yields one result beat with the prediction
// from its 2-bit counter, a mispredict flag and the running miss count. After
// reset the block sweeps the 4096-entry counter table to weakly taken, one
// entry a cycle, and accepts no branch until the sweep ends; config writes
// are taken throughout. Afterwards the back end reads a branch's counter in
// IDLE and, in UPDATE once the result slot is free, writes the stepped counter
// back and registers the result; it takes no new branch until that write, but
// a two-entry queue lets the input side run ahead of a stalled result.
module bimodal_branch_predictor (
  input  logic         clk,
  input  logic         rst,
  bbp_branch_if.sink   branch,
  bbp_cfg_if.sink      cfg,
  bbp_result_if.source result
);
  import bbp_pkg::*;

  logic  q_ready;
  logic  q_push;
  qent_t q_in;
  logic  q_valid;
  logic  q_pop;
  qent_t q_out;
  clr_t  clr;

  logic  back_rd_en;
  idx_t  back_rd_addr;
  ctr_t  rd_data;
  logic  back_wr_en;
  idx_t  back_wr_addr;
  ctr_t  back_wr_data;

  logic  ram_we;
  idx_t  ram_waddr;
  ctr_t  ram_wdata;

  bbp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .branch  (branch),
    .cfg     (cfg),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_data  (q_in),
    .clr     (clr)
  );

  bbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_out)
  );

  bbp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .rd_en   (back_rd_en),
    .rd_addr (back_rd_addr),
    .rd_data (rd_data),
    .wr_en   (back_wr_en),
    .wr_addr (back_wr_addr),
    .wr_data (back_wr_data),
    .result  (result)
  );

  // Clearing pass owns the write port until it finishes
  assign ram_we    = clr.busy || back_wr_en;
  assign ram_waddr = clr.busy ? clr.addr : back_wr_addr;
  assign ram_wdata = clr.busy ? CTR_WEAK_TAKEN : back_wr_data;

  bbp_ram #(
    .WIDTH (CTR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (back_rd_en),
    .raddr (back_rd_addr),
    .rdata (rd_data)
  );

  // No branch enters while the table is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr.busy |-> !branch.ready)
    else $error("branch accepted during table clear");

  // Back end never touches the table during the clearing pass
  a_back_idle_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr.busy |-> (!back_rd_en && !back_wr_en))
    else $error("back end active during table clear");

  // A counter is never read in the cycle it is written
  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (rst)
    !(back_rd_en && ram_we))
    else $error("table read collides with write");

endmodule
